>>> sv/fkct_pkg.sv
// Shared types, constants and helpers for the keyed Fenwick count table.
package fkct_pkg;

	localparam int CNT_W = 20;
	localparam int ACC_W = CNT_W + 4;

	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_DEL   = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MOD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                    valid;
		logic signed [CNT_W-1:0] count;
	} result_t;

	// clamp the wide query sum to the count range
	function automatic logic signed [CNT_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(CNT_MAX);
		lo = ACC_W'(CNT_MIN);
		if (a > hi) begin
			return CNT_MAX;
		end else if (a < lo) begin
			return CNT_MIN;
		end
		return a[CNT_W-1:0];
	endfunction

endpackage

>>> sv/fenwick_keyed_count_table.sv
// Top level: keyed Fenwick count table with count store and output register.
// Flow: an update visits up to log2(TIME_SIZE)+1 nodes, each read in ST_READ and
// written back in ST_MOD; a query reads each node it visits, then ST_FIN hands the
// sum to the output register. One request at a time: input is held off until the
// walk ends and, for a query, until the output register can take the result; the
// single count store is read per node visit and written back only for updates.
// Reset: asynchronous, active low; afterwards the store is swept to zero, one entry
// a cycle over all 2**(TW+KW) entries (65536), input held off.
module fenwick_keyed_count_table #(
	parameter int TIME_SIZE  = 256,
	parameter int VALUE_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [8:0] time_index, [16:9] value_key, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [19:0] prefix_count, rest zero
);

	localparam int TW = $clog2(TIME_SIZE);
	localparam int KW = $clog2(VALUE_SIZE);
	localparam int AW = TW + KW;

	fkct_pkg::result_t res;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [fkct_pkg::CNT_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [fkct_pkg::CNT_W-1:0] ram_rdata;

	// output register: the walker may hand over a result when the slot is
	// empty or is being drained in the same cycle
	logic                       out_valid_q;
	logic [fkct_pkg::CNT_W-1:0] out_count_q;
	logic                       out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	// count store: entry address is {node - 1, key}
	fkct_ram #(
		.WIDTH(fkct_pkg::CNT_W),
		.DEPTH(1 << AW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fkct_ctrl #(
		.TIME_SIZE (TIME_SIZE),
		.VALUE_SIZE(VALUE_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req_type  (s_axis_tuser),
		.time_index(s_axis_tdata[8:0]),
		.value_key (s_axis_tdata[16:9]),
		.out_free  (out_free),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) out_count_q <= res.count;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_count_q};

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !res.valid)
		else $error("pending output beat overwritten");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output beat changed");
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:20] == 4'b0)
		else $error("output padding not zero");
`endif

endmodule

>>> sv/fkct_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module fkct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/fkct_ctrl.sv
// Tree walk sequencer: clear sweep, read-modify-write of node counts, query sum.
module fkct_ctrl #(
	parameter int TIME_SIZE  = 256,
	parameter int VALUE_SIZE = 256,
	localparam int TW = $clog2(TIME_SIZE),
	localparam int KW = $clog2(VALUE_SIZE),
	localparam int AW = TW + KW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [8:0]                    time_index,
	input  logic [7:0]                    value_key,
	input  logic                          out_free,
	output fkct_pkg::result_t             res,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [fkct_pkg::CNT_W-1:0]    ram_wdata,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [fkct_pkg::CNT_W-1:0]    ram_rdata
);

	// node index holds 1..TIME_SIZE and one upward step past it
	localparam int IW = $clog2(TIME_SIZE + 1) + 1;
	localparam logic [IW-1:0] NODE_LAST = IW'(TIME_SIZE);

	fkct_pkg::state_t state_q, state_d;

	logic [AW-1:0]                     clr_q;
	logic [IW-1:0]                     node_q;
	logic [KW-1:0]                     key_q;
	logic                              upd_q;
	logic                              sub_q;
	logic signed [fkct_pkg::ACC_W-1:0] acc_q;

	logic [31:0]   t32;
	logic [31:0]   k32;
	logic [31:0]   tq32;
	logic          key_ok;
	logic          is_upd;
	logic          is_qry;
	logic          upd_go;
	logic          qry_walk;
	logic [IW-1:0] node_m1;
	logic [IW-1:0] lowbit;
	logic [IW-1:0] node_up;
	logic [IW-1:0] node_dn;
	logic signed [fkct_pkg::CNT_W-1:0] cnt;
	logic signed [fkct_pkg::CNT_W-1:0] cnt_new;

	assign t32      = {23'b0, time_index};
	assign k32      = {24'b0, value_key};
	assign tq32     = (t32 > 32'(TIME_SIZE)) ? 32'(TIME_SIZE) : t32;
	assign key_ok   = k32 < 32'(VALUE_SIZE);
	assign is_upd   = (req_type == fkct_pkg::REQ_ADD) || (req_type == fkct_pkg::REQ_DEL);
	assign is_qry   = req_type == fkct_pkg::REQ_QUERY;
	assign upd_go   = is_upd && key_ok && (t32 != 32'd0) && (t32 <= 32'(TIME_SIZE));
	assign qry_walk = is_qry && key_ok && (t32 != 32'd0);

	assign node_m1 = node_q - IW'(1);
	assign lowbit  = node_q & (~node_q + IW'(1));
	assign node_up = node_q + lowbit;
	assign node_dn = node_q - lowbit;

	assign cnt = ram_rdata;
	always_comb begin
		cnt_new = cnt;
		if (sub_q) begin
			if (cnt != fkct_pkg::CNT_MIN) cnt_new = cnt - fkct_pkg::CNT_W'(1);
		end else begin
			if (cnt != fkct_pkg::CNT_MAX) cnt_new = cnt + fkct_pkg::CNT_W'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fkct_pkg::ST_CLEAR: begin
				if (&clr_q) state_d = fkct_pkg::ST_IDLE;
			end
			fkct_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (upd_go || qry_walk) state_d = fkct_pkg::ST_READ;
					else if (is_qry) state_d = fkct_pkg::ST_FIN;
				end
			end
			fkct_pkg::ST_READ: begin
				state_d = fkct_pkg::ST_MOD;
			end
			fkct_pkg::ST_MOD: begin
				if (upd_q) begin
					state_d = (node_up <= NODE_LAST) ? fkct_pkg::ST_READ : fkct_pkg::ST_IDLE;
				end else begin
					state_d = (node_dn != '0) ? fkct_pkg::ST_READ : fkct_pkg::ST_FIN;
				end
			end
			fkct_pkg::ST_FIN: begin
				if (out_free) state_d = fkct_pkg::ST_IDLE;
			end
			default: state_d = fkct_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = {node_m1[TW-1:0], key_q};
		ram_wdata  = cnt_new;
		ram_raddr  = {node_m1[TW-1:0], key_q};
		res.valid  = 1'b0;
		res.count  = fkct_pkg::sat_acc(acc_q);
		unique case (state_q)
			fkct_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			fkct_pkg::ST_IDLE: in_ready = 1'b1;
			fkct_pkg::ST_READ: ;
			fkct_pkg::ST_MOD:  ram_we = upd_q;
			fkct_pkg::ST_FIN:  res.valid = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fkct_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fkct_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	// walk registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			fkct_pkg::ST_IDLE: begin
				node_q <= tq32[IW-1:0];
				key_q  <= k32[KW-1:0];
				upd_q  <= is_upd;
				sub_q  <= req_type == fkct_pkg::REQ_DEL;
				acc_q  <= '0;
			end
			fkct_pkg::ST_MOD: begin
				if (upd_q) begin
					node_q <= node_up;
				end else begin
					node_q <= node_dn;
					acc_q  <= acc_q + fkct_pkg::ACC_W'(cnt);
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != fkct_pkg::ST_IDLE |-> !in_ready)
		else $error("input accepted while walking or clearing");
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == fkct_pkg::ST_CLEAR) || (state_q == fkct_pkg::ST_MOD && upd_q))
		else $error("count store written outside clear or update");
	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fkct_pkg::ST_READ |-> (node_q != '0) && (node_q <= NODE_LAST))
		else $error("tree node out of range");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> !res.valid)
		else $error("query produced two results");
`endif

endmodule

>>> tb/sv/fenwick_keyed_count_table_tb.sv
// Testbench for the keyed Fenwick count table: directed table, weighted random traffic, scoreboard.
`timescale 1ns / 1ps

module fenwick_keyed_count_table_tb;

	localparam int TIME_SIZE      = 256;
	localparam int VALUE_SIZE     = 256;
	localparam int CLK_HALF       = 6;
	localparam int RAND_ITEMS     = 1326;  // random requests after the directed table
	localparam int QUIET_TAIL     = 150;   // final stretch with no idling at all
	localparam int PAUSE_AT       = 700;   // sender waits for an empty scoreboard here
	localparam int HOLD_AT_BEAT   = 150;   // receiver's long hold-off starts after this beat
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;    // covers a full update walk with margin
	localparam int DRAIN_GUARD    = 100000;
	localparam int TIMEOUT_CYCLES = 600000; // outlasts the clear sweep of all 65536 store entries

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [8:0] time_index, [16:9] value_key, rest zero
	logic [1:0]  s_axis_tuser;   // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [19:0] prefix_count, rest zero

	// one row of the directed table; exp_cnt only used when has_exp is set
	typedef struct {
		fkct_pkg::req_t                    op;
		logic [8:0]                        tpos;
		logic [7:0]                        key;
		bit                                has_exp;
		logic signed [fkct_pkg::CNT_W-1:0] exp_cnt;
	} req_row_t;

	// private copy of the count store: [time node][key]
	logic signed [fkct_pkg::CNT_W-1:0] node_cnt [1:TIME_SIZE][0:VALUE_SIZE-1];

	logic signed [fkct_pkg::CNT_W-1:0] pending_counts[$];  // query results still owed
	req_row_t                          directed_rows[$];
	int                                mismatches;
	int                                beats_seen;
	bit                                no_idle;

	fenwick_keyed_count_table #(
		.TIME_SIZE (TIME_SIZE),
		.VALUE_SIZE(VALUE_SIZE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#(CLK_HALF);
		clk = 1'b0;
		#(CLK_HALF);
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic signed [fkct_pkg::CNT_W-1:0] clamp_cnt(input int v);
		if (v > int'(fkct_pkg::CNT_MAX)) begin
			return fkct_pkg::CNT_MAX;
		end else if (v < int'(fkct_pkg::CNT_MIN)) begin
			return fkct_pkg::CNT_MIN;
		end
		return v[fkct_pkg::CNT_W-1:0];
	endfunction

	// upward walk: every node covering tpos moves by delta, each one saturating on its own
	function automatic void tally(input logic [8:0] tpos, input logic [7:0] key,
			input int delta);
		int i;
		i = int'(tpos);
		while (i <= TIME_SIZE) begin
			node_cnt[i][key] = clamp_cnt(node_cnt[i][key] + delta);
			i += i & (-i);
		end
	endfunction

	// downward walk; anything past the last time reads as the whole range
	function automatic logic signed [fkct_pkg::CNT_W-1:0] prefix_sum(input logic [8:0] tpos,
			input logic [7:0] key);
		int i;
		int acc;
		i = (int'(tpos) > TIME_SIZE) ? TIME_SIZE : int'(tpos);
		acc = 0;
		while (i > 0) begin
			acc += node_cnt[i][key];
			i -= i & (-i);
		end
		return clamp_cnt(acc);
	endfunction

	// true when the block does nothing with the request: reserved code, or an
	// update outside 1..TIME_SIZE
	function automatic bit is_ignored(input fkct_pkg::req_t op, input logic [8:0] tpos);
		if (op == fkct_pkg::REQ_RSVD) begin
			return 1'b1;
		end
		if (op == fkct_pkg::REQ_QUERY) begin
			return 1'b0;
		end
		return (tpos == 9'd0) || (int'(tpos) > TIME_SIZE);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers; inputs only move on the falling edge
	// ------------------------------------------------------------------

	// offer one beat, wait for the handshake, then fold it into the predictor
	task automatic send_req(input fkct_pkg::req_t op, input logic [8:0] tpos,
			input logic [7:0] key, input bit has_exp,
			input logic signed [fkct_pkg::CNT_W-1:0] exp_cnt);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, key, tpos};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		if (op == fkct_pkg::REQ_QUERY) begin
			pending_counts.push_back(has_exp ? exp_cnt : prefix_sum(tpos, key));
		end else if (!is_ignored(op, tpos)) begin
			tally(tpos, key, (op == fkct_pkg::REQ_ADD) ? 1 : -1);
		end
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic add_row(input fkct_pkg::req_t op, input int tpos, input int key,
			input bit has_exp = 1'b0, input int exp_cnt = 0);
		req_row_t r;
		r.op      = op;
		r.tpos    = tpos[8:0];
		r.key     = key[7:0];
		r.has_exp = has_exp;
		r.exp_cnt = exp_cnt[fkct_pkg::CNT_W-1:0];
		directed_rows.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Result checker: compares each output beat with the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin : result_check
		logic signed [fkct_pkg::CNT_W-1:0] got;
		logic signed [fkct_pkg::CNT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[fkct_pkg::CNT_W-1:0];
			beats_seen++;
			if (pending_counts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, got prefix_count %0d",
					$time, got);
			end else begin
				want = pending_counts.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: prefix_count mismatch, expected %0d, got %0d",
						$time, want, got);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold-off, calm stretches
	// ------------------------------------------------------------------

	initial begin : result_ready
		bit hold_done;
		bit calm;
		hold_done = 1'b0;
		calm      = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0) begin
				calm = !calm;
			end
			if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
				// long back-pressure: the output register fills and the input stalls
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!no_idle && !calm && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : main_seq
		int             done_items;
		int             guard;
		int             r;
		fkct_pkg::req_t op;
		logic [8:0]     tpos;
		logic [7:0]     key;
		logic [7:0]     hot_keys [0:5];
		req_row_t       row;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = fkct_pkg::REQ_ADD;
		mismatches    = 0;
		beats_seen    = 0;
		no_idle       = 1'b0;
		foreach (node_cnt[i, j]) begin
			node_cnt[i][j] = '0;
		end
		foreach (hot_keys[i]) begin
			hot_keys[i] = 8'($urandom_range(0, VALUE_SIZE - 1));
		end

		// directed table: empty store, range ends, ignored requests, negative counts
		add_row(fkct_pkg::REQ_QUERY, 256, 0,   1, 0);   // fresh store reads zero
		add_row(fkct_pkg::REQ_QUERY, 0,   255, 1, 0);   // empty prefix
		add_row(fkct_pkg::REQ_QUERY, 511, 128, 1, 0);   // past the end, all ones
		add_row(fkct_pkg::REQ_ADD,   1,   0);           // lowest time, lowest key
		add_row(fkct_pkg::REQ_ADD,   256, 255);         // highest time, highest key
		add_row(fkct_pkg::REQ_ADD,   0,   5);           // update at time zero: dropped
		add_row(fkct_pkg::REQ_ADD,   257, 5);           // just past last time: dropped
		add_row(fkct_pkg::REQ_DEL,   511, 5);           // far past last time: dropped
		add_row(fkct_pkg::REQ_RSVD,  3,   5);           // reserved code: dropped
		add_row(fkct_pkg::REQ_QUERY, 256, 5,   1, 0);   // none of the dropped ones landed
		add_row(fkct_pkg::REQ_QUERY, 1,   0,   1, 1);
		add_row(fkct_pkg::REQ_QUERY, 0,   0,   1, 0);
		add_row(fkct_pkg::REQ_QUERY, 511, 255, 1, 1);   // clipped to TIME_SIZE
		add_row(fkct_pkg::REQ_QUERY, 255, 255, 1, 0);
		add_row(fkct_pkg::REQ_DEL,   100, 7);           // remove with no add before it
		add_row(fkct_pkg::REQ_QUERY, 256, 7,   1, -1);
		add_row(fkct_pkg::REQ_QUERY, 99,  7,   1, 0);
		add_row(fkct_pkg::REQ_ADD,   170, 7);
		add_row(fkct_pkg::REQ_ADD,   85,  7);
		add_row(fkct_pkg::REQ_QUERY, 170, 7);
		add_row(fkct_pkg::REQ_QUERY, 128, 7);
		add_row(fkct_pkg::REQ_RSVD,  511, 255);
		add_row(fkct_pkg::REQ_DEL,   1,   0);
		add_row(fkct_pkg::REQ_QUERY, 256, 0,   1, 0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// the block sweeps its store after reset; the first handshake waits it out
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_req(row.op, row.tpos, row.key, row.has_exp, row.exp_cnt);
			if ($urandom_range(0, 2) == 0) begin
				idle_gap($urandom_range(1, 12));
			end
		end

		// random part: a few hot keys so counts build up, ignored requests as noise
		done_items = 0;
		while (done_items < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				op = fkct_pkg::REQ_ADD;
			end else if (r < 55) begin
				op = fkct_pkg::REQ_DEL;
			end else if (r < 95) begin
				op = fkct_pkg::REQ_QUERY;
			end else begin
				op = fkct_pkg::REQ_RSVD;
			end
			r = $urandom_range(0, 99);
			if (r < 5) begin
				tpos = 9'd0;
			end else if (r < 10) begin
				tpos = 9'($urandom_range(TIME_SIZE + 1, 511));
			end else if (r < 20) begin
				tpos = 9'(1 << $urandom_range(0, 8));   // single-node query walks and the top
			end else begin
				tpos = 9'($urandom_range(1, TIME_SIZE));
			end
			if ($urandom_range(0, 3) != 0) begin
				key = hot_keys[$urandom_range(0, 5)];
			end else begin
				key = 8'($urandom_range(0, VALUE_SIZE - 1));
			end

			send_req(op, tpos, key, 1'b0, '0);
			done_items++;

			if (done_items == RAND_ITEMS - QUIET_TAIL) begin
				no_idle = 1'b1;
			end
			if (done_items == PAUSE_AT) begin
				// sender stops until every owed result is out and any update walk is done
				idle_gap(1);
				while (pending_counts.size() != 0) begin
					@(posedge clk);
				end
				repeat (DRAIN_CYCLES) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				idle_gap($urandom_range(1, 12));
			end
		end
		idle_gap(1);

		// drain: wait for owed results, bounded, then let the last walk finish
		guard = 0;
		while (pending_counts.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_counts.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived, expected prefix_count %0d, got none",
				$time, pending_counts.size(), pending_counts[0]);
		end

		if (mismatches == 0) begin
			$display("PASS fenwick_keyed_count_table");
		end else begin
			$display("FAIL fenwick_keyed_count_table");
		end
		$finish;
	end

	// watchdog: clear sweep plus the slowest legal traffic, many times over
	initial begin : watchdog
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("FAIL fenwick_keyed_count_table");
		$finish;
	end

endmodule
